// ===== design/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the tick task release scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_REPORT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_SUM  = 2'd2
  } state_t;

  typedef struct packed {
    logic [15:0] countdown;
    logic [15:0] reload;
  } tts_entry_t;

  typedef struct packed {
    logic [15:0] countdown;
    logic        fire;
  } tts_upd_t;

endpackage

// ===== design/tts_ram.sv =====
// ----------------------------------------------------------------------------
// tts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tts_entry.sv =====
// ----------------------------------------------------------------------------
// tts_entry
// Per-entry tick update: down-count or reload, and release decision.
// ----------------------------------------------------------------------------
module tts_entry (
  input  tts_pkg::tts_entry_t ent,
  input  logic                nc,
  output tts_pkg::tts_upd_t   upd
);

  import tts_pkg::*;

  logic zero;

  assign zero = (ent.countdown == 16'd0);

  always_comb begin
    upd.countdown = zero ? ent.reload : ent.countdown - 16'd1;
    upd.fire      = zero | nc;
  end

endmodule

// ===== design/tick_task_release_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_task_release_scheduler
// Task table of down-counters kept in RAM; add, tick walk and report commands.
// ----------------------------------------------------------------------------
// add and report: one result the cycle after start, busy stays low
// tick: one RAM read-modify-write per table entry, busy from the walk through
//   the summary; dispatch beats follow in entry order, summary last
// the receiver cannot stall; each result beat is out_valid for one cycle
// reset clears the task count, overrun count and limit (to 3); the table
//   RAM is not cleared, entries are written by add before a tick walk reads them
module tick_task_release_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_initial_delay,
  input  logic [15:0] in_period,
  input  logic [3:0]  in_task_index,
  input  logic        in_task_completed,
  input  logic        in_tick_pending_again,
  input  logic        in_overrun_check_ignored,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_dispatched_task,
  output logic        out_ok,
  output logic        out_overrun_error,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  import tts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]        ovr_r, ovr_nxt;
  logic [7:0]         limit_r;
  logic               pend_r, pend_nxt;
  logic               ign_r, ign_nxt;

  logic               accept;
  logic [CMP_W-1:0]   tidx_cmp;
  logic [15:0]        ovr_inc;

  logic               tab_we, flag_we;
  logic [IDX_W-1:0]   waddr, raddr;
  tts_entry_t         tab_wdata, tab_rdata;
  logic [0:0]         flag_wdata, flag_rdata;
  tts_upd_t           upd;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [3:0]         out_task_r, out_task_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_last_r, out_last_nxt;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;
  assign tidx_cmp = CMP_W'(in_task_index);
  assign ovr_inc  = (ovr_r == 16'hFFFF) ? ovr_r : ovr_r + 16'd1;

  tts_ram #(.WIDTH($bits(tts_entry_t)), .DEPTH(MAX_TASKS)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (waddr),
    .wdata (tab_wdata),
    .raddr (raddr),
    .rdata (tab_rdata)
  );

  tts_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (waddr),
    .wdata (flag_wdata),
    .raddr (raddr),
    .rdata (flag_rdata)
  );

  tts_entry u_entry (
    .ent (tab_rdata),
    .nc  (flag_rdata[0]),
    .upd (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ovr_nxt       = ovr_r;
    pend_nxt      = pend_r;
    ign_nxt       = ign_r;
    tab_we        = 1'b0;
    flag_we       = 1'b0;
    waddr         = idx_r;
    tab_wdata     = '{countdown: in_initial_delay, reload: in_period - 16'd1};
    flag_wdata    = 1'b0;
    raddr         = '0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_DISPATCH;
    out_task_nxt  = 4'd0;
    out_ok_nxt    = 1'b0;
    out_err_nxt   = 1'b0;
    out_last_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ADD;
              out_last_nxt  = 1'b1;
              if (cnt_r < CNT_W'(MAX_TASKS)) begin
                tab_we       = 1'b1;
                flag_we      = 1'b1;
                waddr        = cnt_r[IDX_W-1:0];
                out_task_nxt = 4'(cnt_r);
                out_ok_nxt   = 1'b1;
                cnt_nxt      = cnt_r + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              pend_nxt  = in_tick_pending_again;
              ign_nxt   = in_overrun_check_ignored;
              idx_nxt   = '0;
              state_nxt = (cnt_r == '0) ? ST_SUM : ST_WALK;
            end
            CMD_REPORT: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REPORT;
              out_task_nxt  = in_task_index;
              out_last_nxt  = 1'b1;
              if (tidx_cmp < CMP_W'(cnt_r)) begin
                flag_we    = 1'b1;
                waddr      = tidx_cmp[IDX_W-1:0];
                flag_wdata = ~in_task_completed;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        tab_we        = 1'b1;
        flag_we       = 1'b1;
        tab_wdata     = '{countdown: upd.countdown, reload: tab_rdata.reload};
        flag_wdata    = flag_rdata | upd.fire;
        out_valid_nxt = upd.fire;
        out_kind_nxt  = KIND_DISPATCH;
        out_task_nxt  = 4'(idx_r);
        raddr         = idx_r + IDX_W'(1);
        if (CNT_W'(idx_r) + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_SUM;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_SUM: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_TICK;
        out_last_nxt  = 1'b1;
        if (pend_r & ~ign_r) begin
          ovr_nxt     = ovr_inc;
          out_err_nxt = (ovr_inc > {8'd0, limit_r});
        end else begin
          ovr_nxt = 16'd0;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      ovr_r       <= 16'd0;
      limit_r     <= 8'd3;
      pend_r      <= 1'b0;
      ign_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      ovr_r       <= ovr_nxt;
      pend_r      <= pend_nxt;
      ign_r       <= ign_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_task_r <= out_task_nxt;
    out_ok_r   <= out_ok_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_dispatched_task = out_task_r;
  assign out_ok              = out_ok_r;
  assign out_overrun_error   = out_err_r;
  assign out_last            = out_last_r;

endmodule

// ===== design/tts_checker.sv =====
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks for the tick task release scheduler, bound to the top.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic       out_ok,
  input logic       out_overrun_error,
  input logic       out_last
);

  import tts_pkg::*;

  logic accept;

  assign accept = start & ~busy;

  a_add_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_ADD |=> out_valid && out_kind == KIND_ADD && out_last)
    else $error("add without acknowledge beat");

  a_report_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_REPORT |=>
      out_valid && out_kind == KIND_REPORT && out_last && !out_ok)
    else $error("report without acknowledge beat");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_TICK |=> busy)
    else $error("tick did not start a walk");

  a_err_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TICK |-> !out_overrun_error)
    else $error("overrun error outside tick summary");

  a_dispatch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DISPATCH |-> !out_last && !out_ok && busy)
    else $error("bad dispatch beat");

endmodule

bind tick_task_release_scheduler tts_checker u_tts_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_task_release_scheduler testbench
// Drives add, tick and report commands through the start/busy port.
// Each beat is checked by field against a directed row or an in-bench model
// of the task table, the countdowns and the overrun counter. A short
// directed table comes first, then four random phases, each run under its
// own overrun limit. Gaps between commands come in random stretches.
// ----------------------------------------------------------------------------
module testbench;
  import tts_pkg::*;

  localparam int          MAX_TASKS   = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = 24;
  localparam int          PHASE_BEATS = 25;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] delay;
    logic [15:0] period;
    logic [3:0]  idx;
    logic        done;
    logic        pend;
    logic        ign;
  } cmd_beat_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] slot;
    logic       ok;
    logic       err;
    logic       last;
  } res_beat_t;

  typedef struct packed {
    cmd_beat_t  b;
    logic       typed;
    res_beat_t  r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [15:0] in_initial_delay = '0;
  logic [15:0] in_period = '0;
  logic [3:0]  in_task_index = '0;
  logic        in_task_completed = 1'b0;
  logic        in_tick_pending_again = 1'b0;
  logic        in_overrun_check_ignored = 1'b0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_dispatched_task;
  logic        out_ok;
  logic        out_overrun_error;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // scheduler model state
  logic [4:0]  tbl_count;
  logic [15:0] tbl_countdown [MAX_TASKS];
  logic [15:0] tbl_reload [MAX_TASKS];
  logic        tbl_running [MAX_TASKS];
  logic [15:0] overrun_cnt;
  logic [7:0]  overrun_limit;

  res_beat_t   step_res [MAX_TASKS + 1];
  int          step_n;
  res_beat_t   expected_beats [$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          cmds_sent = 0;
  int          beats_checked = 0;
  int          dispatches_seen = 0;
  int          overrun_flags_seen = 0;
  int          adds_rejected = 0;
  bit          heavy_idle = 1'b0;

  dir_row_t    dir_tab [19];

  tick_task_release_scheduler #(.MAX_TASKS(MAX_TASKS)) u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_command               (in_command),
    .in_initial_delay         (in_initial_delay),
    .in_period                (in_period),
    .in_task_index            (in_task_index),
    .in_task_completed        (in_task_completed),
    .in_tick_pending_again    (in_tick_pending_again),
    .in_overrun_check_ignored (in_overrun_check_ignored),
    .out_valid                (out_valid),
    .out_kind                 (out_kind),
    .out_dispatched_task      (out_dispatched_task),
    .out_ok                   (out_ok),
    .out_overrun_error        (out_overrun_error),
    .out_last                 (out_last),
    .cfg_we                   (cfg_we),
    .cfg_wdata                (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_result(input kind_t kind, input logic [3:0] slot, input logic ok,
                             input logic err, input logic last);
    step_res[step_n] = '{kind, slot, ok, err, last};
    step_n++;
  endtask

  // applies one command to the model table and collects its result beats
  task automatic schedule_step(input cmd_beat_t b);
    logic fire;
    logic err;
    step_n = 0;
    case (b.cmd)
      CMD_ADD: begin
        if (tbl_count < MAX_TASKS) begin
          tbl_countdown[tbl_count[3:0]] = b.delay;
          tbl_reload[tbl_count[3:0]] = b.period - 16'd1;
          tbl_running[tbl_count[3:0]] = 1'b0;
          push_result(KIND_ADD, tbl_count[3:0], 1'b1, 1'b0, 1'b1);
          tbl_count++;
        end else begin
          push_result(KIND_ADD, 4'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_countdown[i] != 16'd0) begin
            tbl_countdown[i] = tbl_countdown[i] - 16'd1;
            fire = tbl_running[i];
          end else begin
            fire = 1'b1;
            tbl_countdown[i] = tbl_reload[i];
          end
          if (fire) begin
            tbl_running[i] = 1'b1;
            push_result(KIND_DISPATCH, 4'(i), 1'b0, 1'b0, 1'b0);
          end
        end
        err = 1'b0;
        if (b.pend && !b.ign) begin
          if (overrun_cnt != 16'hFFFF) overrun_cnt++;
          err = overrun_cnt > {8'd0, overrun_limit};
        end else begin
          overrun_cnt = '0;
        end
        push_result(KIND_TICK, 4'd0, 1'b0, err, 1'b1);
      end
      CMD_REPORT: begin
        if (b.idx < tbl_count) tbl_running[b.idx] = ~b.done;
        push_result(KIND_REPORT, b.idx, 1'b0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic issue(input cmd_beat_t b, input logic typed, input res_beat_t want);
    int gap;
    gap = heavy_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command               <= b.cmd;
    in_initial_delay         <= b.delay;
    in_period                <= b.period;
    in_task_index            <= b.idx;
    in_task_completed        <= b.done;
    in_tick_pending_again    <= b.pend;
    in_overrun_check_ignored <= b.ign;
    start                    <= 1'b1;
    do @(posedge clk); while (busy);
    schedule_step(b);
    if (typed) expected_beats.push_back(want);
    else for (int k = 0; k < step_n; k++) expected_beats.push_back(step_res[k]);
    cmds_sent++;
    if (cmds_sent % 10 == 0) heavy_idle = $urandom_range(0, 1);
  endtask

  task automatic write_overrun_limit(input logic [7:0] value);
    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    overrun_limit = value;
  endtask

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      b.cmd = CMD_ADD;
    else if (pick < 70) b.cmd = CMD_TICK;
    else if (pick < 95) b.cmd = CMD_REPORT;
    else                b.cmd = CMD_UNUSED;
    b.delay  = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    b.period = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
    b.idx    = 4'($urandom_range(0, 15));
    b.done   = $urandom_range(0, 9) < 6;
    b.pend   = $urandom_range(0, 9) < 7;
    b.ign    = $urandom_range(0, 19) < 3;
    return b;
  endfunction

  // result checker, the receiver never stalls
  always @(posedge clk) begin
    res_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d task %0d", out_kind,
                                  out_dispatched_task));
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_dispatched_task !== want.slot)
          report_mismatch($sformatf("dispatched_task %0d, want %0d",
                                    out_dispatched_task, want.slot));
        if (out_ok !== want.ok)
          report_mismatch($sformatf("ok %0b, want %0b", out_ok, want.ok));
        if (out_overrun_error !== want.err)
          report_mismatch($sformatf("overrun_error %0b, want %0b",
                                    out_overrun_error, want.err));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        if (want.kind == KIND_DISPATCH) dispatches_seen++;
        if (want.err) overrun_flags_seen++;
        if (want.kind == KIND_ADD && !want.ok) adds_rejected++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_beats.size());
      $display("tick_task_release_scheduler test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_limit [4];
    res_beat_t  none;
    none = '{KIND_DISPATCH, 4'd0, 1'b0, 1'b0, 1'b0};

    dir_tab = '{
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_TICK,   4'd0,  1'b0, 1'b0, 1'b1}},
      '{'{CMD_REPORT, 16'd0,      16'd0,      4'd15, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{KIND_REPORT, 4'd15, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_ADD,    16'd0,      16'd0,      4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_ADD,    4'd0,  1'b1, 1'b0, 1'b1}},
      '{'{CMD_ADD,    16'hFFFF,   16'hFFFF,   4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_ADD,    4'd1,  1'b1, 1'b0, 1'b1}},
      '{'{CMD_ADD,    16'd1,      16'd1,      4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_ADD,    4'd2,  1'b1, 1'b0, 1'b1}},
      '{'{CMD_ADD,    16'd2,      16'd3,      4'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_ADD,    4'd3,  1'b1, 1'b0, 1'b1}},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b0}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b1}, 1'b0, none},
      '{'{CMD_REPORT, 16'd0,      16'd0,      4'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
        '{KIND_REPORT, 4'd0,  1'b0, 1'b0, 1'b1}},
      '{'{CMD_REPORT, 16'd0,      16'd0,      4'd2,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_REPORT, 4'd2,  1'b0, 1'b0, 1'b1}},
      '{'{CMD_REPORT, 16'd0,      16'd0,      4'd9,  1'b0, 1'b0, 1'b0}, 1'b1,
        '{KIND_REPORT, 4'd9,  1'b0, 1'b0, 1'b1}},
      '{'{CMD_UNUSED, 16'hFFFF,   16'hFFFF,   4'd15, 1'b1, 1'b1, 1'b1}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b0}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b0}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b0}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b1, 1'b0}, 1'b0, none},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b0, 1'b0}, 1'b0, none},
      '{'{CMD_REPORT, 16'd0,      16'd0,      4'd1,  1'b1, 1'b0, 1'b0}, 1'b1,
        '{KIND_REPORT, 4'd1,  1'b0, 1'b0, 1'b1}},
      '{'{CMD_TICK,   16'd0,      16'd0,      4'd0,  1'b0, 1'b0, 1'b1}, 1'b0, none}
    };

    tbl_count     = '0;
    overrun_cnt   = '0;
    overrun_limit = 8'd3;
    for (int i = 0; i < MAX_TASKS; i++) begin
      tbl_countdown[i] = '0;
      tbl_reload[i]    = '0;
      tbl_running[i]   = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) issue(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].r);

    phase_limit[0] = 8'd0;
    phase_limit[1] = 8'd255;
    phase_limit[2] = 8'($urandom_range(1, 254));
    phase_limit[3] = 8'd1;
    for (int p = 0; p < 4; p++) begin
      write_overrun_limit(phase_limit[p]);
      for (int n = 0; n < PHASE_BEATS; n++) issue(random_beat(), 1'b0, none);
    end

    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d commands, %0d result beats checked, %0d dispatches", cmds_sent,
             beats_checked, dispatches_seen);
    $display("%0d overrun flags, %0d adds rejected on a full table, %0d mismatches",
             overrun_flags_seen, adds_rejected, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tick_task_release_scheduler test passed");
    end else begin
      $display("tick_task_release_scheduler test failed");
    end
    $finish;
  end

endmodule
